// File: hw/rtl/two_class_age_ordered_fifo_macros.svh
// assertion macros for the two-class age-ordered fifo
`ifndef TWO_CLASS_AGE_ORDERED_FIFO_MACROS_SVH
`define TWO_CLASS_AGE_ORDERED_FIFO_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TCAOF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define TCAOF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define TCAOF_ASSERT_SAME(label, ante, cons)

`define TCAOF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/tcaof_pkg.sv
package tcaof_pkg;

   localparam int DEPTH      = 16;
   localparam int TAG_BITS   = 16;
   localparam int STAMP_BITS = $clog2(DEPTH) + 1;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   localparam logic [1:0] CMD_ENQ  = 2'd0;
   localparam logic [1:0] CMD_DEQ0 = 2'd1;
   localparam logic [1:0] CMD_DEQ1 = 2'd2;
   localparam logic [1:0] CMD_ANY  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]          command;
      logic                item_class;
      logic [TAG_BITS-1:0] item_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [TAG_BITS-1:0] out_tag;
      logic                out_class;
   } rsp_type;

   typedef struct packed {
      logic [STAMP_BITS-1:0] stamp;
      logic [TAG_BITS-1:0]   tag;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// File: hw/rtl/tcaof_cell.sv
module tcaof_cell (
   input  logic                     clock,
   input  tcaof_pkg::cell_ctl_type  ctl,
   input  tcaof_pkg::entry_type     load_entry,
   input  tcaof_pkg::entry_type     next_entry,
   output tcaof_pkg::entry_type     entry
);
   import tcaof_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = next_entry;
      end else if (ctl.load) begin
         entry_in = load_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: hw/rtl/tcaof_queue.sv
`include "two_class_age_ordered_fifo_macros.svh"

module tcaof_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  tcaof_pkg::queue_ctl_type        ctl,
   input  tcaof_pkg::entry_type            push_entry,
   output tcaof_pkg::entry_type            head,
   output logic                            empty,
   output logic                            full
);
   import tcaof_pkg::*;

   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   entry_type           cells [DEPTH];

   // cell 0 is the head; a pop shifts every cell one place towards it
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_type cctl;
      entry_type    nxt;
      assign cctl.shift = ctl.pop;
      assign cctl.load  = ctl.push && (count_ff == CNT_BITS'(i));
      if (i == DEPTH - 1) begin : g_last
         assign nxt = cells[i];
      end else begin : g_mid
         assign nxt = cells[i+1];
      end
      tcaof_cell u_cell (
         .clock      (clock),
         .ctl        (cctl),
         .load_entry (push_entry),
         .next_entry (nxt),
         .entry      (cells[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = cells[0];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_BITS'(DEPTH));

   `TCAOF_ASSERT_SAME(a_no_push_full, ctl.push, !full)
   `TCAOF_ASSERT_SAME(a_no_pop_empty, ctl.pop, !empty && !ctl.push)
   `TCAOF_ASSERT_NEXT(a_pop_count, ctl.pop, count_ff == $past(count_ff) - CNT_BITS'(1))
   `TCAOF_ASSERT_NEXT(a_pop_head, ctl.pop && (count_ff > CNT_BITS'(1)), head == $past(cells[1]))

endmodule

// File: hw/rtl/two_class_age_ordered_fifo.sv
// two-class age-ordered fifo
// req channel: req_valid / req_ready carry one command word (enqueue, dequeue
// class zero, dequeue class one, dequeue oldest of either class)
// rsp channel: rsp_valid / rsp_ready return exactly one word per command with
// status, dequeued tag and its class
// each class queue is a row of cells with the head in the first cell; a pop
// shifts the whole row by one, a push loads the cell at the fill level
// the response word is registered and is offered in the cycle after the command word is accepted
// throughput: one command per cycle while the response side keeps taking words;
// the single output register sets this figure
// when the receiver stalls, the response word holds and req_ready stays low
// until it is taken
// reset empties both queues, clears the arrival stamp and drops any pending
// response word
`include "two_class_age_ordered_fifo_macros.svh"

module two_class_age_ordered_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tcaof_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcaof_pkg::rsp_type rsp_word
);
   import tcaof_pkg::*;

   logic                  accept;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [STAMP_BITS-1:0] stamp_ff;
   logic [STAMP_BITS-1:0] stamp_in;
   logic [STAMP_BITS-1:0] diff;
   logic                  one_older;
   logic                  pop_sel;
   logic                  do_pop;
   logic                  push_full;
   queue_ctl_type         ctl0;
   queue_ctl_type         ctl1;
   entry_type             push_entry;
   entry_type             head0;
   entry_type             head1;
   logic                  empty0;
   logic                  empty1;
   logic                  full0;
   logic                  full1;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign push_entry.stamp = stamp_ff;
   assign push_entry.tag   = req_word.item_tag;

   assign diff      = head0.stamp - head1.stamp;
   assign one_older = (diff != '0) && !diff[STAMP_BITS-1];
   assign push_full = req_word.item_class ? full1 : full0;

   always_comb begin
      pop_sel = 1'b0;
      do_pop  = 1'b0;
      unique case (req_word.command)
         CMD_ENQ: begin
            pop_sel = 1'b0;
         end
         CMD_DEQ0: begin
            pop_sel = 1'b0;
         end
         CMD_DEQ1: begin
            pop_sel = 1'b1;
         end
         default: begin
            priority if (empty0) begin
               pop_sel = 1'b1;
            end else if (empty1) begin
               pop_sel = 1'b0;
            end else begin
               pop_sel = one_older;
            end
         end
      endcase
      if (req_word.command != CMD_ENQ) begin
         do_pop = pop_sel ? !empty1 : !empty0;
      end
   end

   always_comb begin
      ctl0     = '0;
      ctl1     = '0;
      stamp_in = stamp_ff;
      rsp_in   = rsp_ff;
      if (accept) begin
         rsp_in = '0;
         if (req_word.command == CMD_ENQ) begin
            if (push_full) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status = ST_OK;
               ctl0.push     = !req_word.item_class;
               ctl1.push     = req_word.item_class;
               stamp_in      = stamp_ff + STAMP_BITS'(1);
            end
         end else if (do_pop) begin
            rsp_in.status    = ST_OK;
            rsp_in.out_tag   = pop_sel ? head1.tag : head0.tag;
            rsp_in.out_class = pop_sel;
            ctl0.pop         = !pop_sel;
            ctl1.pop         = pop_sel;
         end else begin
            rsp_in.status = ST_EMPTY;
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         stamp_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         stamp_ff     <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   tcaof_queue u_queue0 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl0),
      .push_entry (push_entry),
      .head       (head0),
      .empty      (empty0),
      .full       (full0)
   );

   tcaof_queue u_queue1 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl1),
      .push_entry (push_entry),
      .head       (head1),
      .empty      (empty1),
      .full       (full1)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `TCAOF_ASSERT_NEXT(a_accept_rsp, accept, rsp_valid_ff)
   `TCAOF_ASSERT_SAME(a_one_queue_op, 1'b1, $countones({ctl0, ctl1}) <= 1)
   `TCAOF_ASSERT_NEXT(a_stamp_push, ctl0.push || ctl1.push, stamp_ff == $past(stamp_ff) + STAMP_BITS'(1))

endmodule
